// ----- hw/rtl/adc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_pkg: shared types and constants for the add-with-carry executor
// Item kinds, opcodes, register selects, status bit positions and the adder
// result bundle.
// ----------------------------------------------------------------------------
package adc_pkg;

   // Kind of work carried by one input transfer
   typedef enum logic [1:0] {
      KIND_EXEC        = 2'd0,
      KIND_LOAD        = 2'd1,
      KIND_PRESET_REG  = 2'd2,
      KIND_PRESET_FLAG = 2'd3
   } kind_type;

   // ADC opcodes, all of the form 011x_xx01
   localparam logic [7:0] OP_INDX = 8'h61;
   localparam logic [7:0] OP_ZP   = 8'h65;
   localparam logic [7:0] OP_IMM  = 8'h69;
   localparam logic [7:0] OP_ABS  = 8'h6D;
   localparam logic [7:0] OP_INDY = 8'h71;
   localparam logic [7:0] OP_ZPX  = 8'h75;
   localparam logic [7:0] OP_ABSY = 8'h79;
   localparam logic [7:0] OP_ABSX = 8'h7D;

   // Register preset selects
   localparam logic [1:0] SEL_A    = 2'd0;
   localparam logic [1:0] SEL_X    = 2'd1;
   localparam logic [1:0] SEL_Y    = 2'd2;
   localparam logic [1:0] SEL_NONE = 2'd3;

   // Status register bit positions
   localparam int ST_C = 0;
   localparam int ST_Z = 1;
   localparam int ST_D = 3;
   localparam int ST_V = 6;
   localparam int ST_N = 7;

   // Adder result: new accumulator and new status byte
   typedef struct packed {
      logic [7:0] sum;
      logic [7:0] status;
   } alu_out_type;

endpackage : adc_pkg
`default_nettype wire

// ----- hw/rtl/adc_mem.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_mem: byte-wide data memory
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module adc_mem #(
   parameter int ADDR_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [7:0]           wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [7:0]           rd_data
);

   localparam int DEPTH = 1 << ADDR_BITS;

   logic [7:0] mem_ff [DEPTH];

   // Store a byte
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read; hold the last data while idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule : adc_mem
`default_nettype wire

// ----- hw/rtl/adc_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// adc_alu: binary add with carry
// Adds operand and carry to the accumulator and rebuilds C, Z, V and N.
// ----------------------------------------------------------------------------
module adc_alu (
   input  wire logic [7:0]          acc,
   input  wire logic [7:0]          status,
   input  wire logic [7:0]          operand,
   output adc_pkg::alu_out_type     result
);

   import adc_pkg::*;

   logic [8:0] sum9;
   logic [7:0] r;

   // Nine-bit sum keeps the carry out
   assign sum9 = {1'b0, acc} + {1'b0, operand} + {8'd0, status[ST_C]};
   assign r    = sum9[7:0];

   // Replace the four arithmetic flags, keep the rest
   always_comb begin
      result.sum          = r;
      result.status       = status;
      result.status[ST_C] = sum9[8];
      result.status[ST_Z] = (r == 8'd0);
      result.status[ST_V] = (acc[7] ^ r[7]) & (operand[7] ^ r[7]);
      result.status[ST_N] = r[7];
   end

endmodule : adc_alu
`default_nettype wire

// ----- hw/rtl/adc_instruction_executor.sv -----
`default_nettype none
// Path: immediate, direct and indexed modes, loads and presets pass the issue
//   and finish stages; the two indirect modes first pass S_PTR_HI and S_PTR_FIN.
// Throughput: one item per cycle unless results stall; indirect modes hold the
//   issue stage in S_PTR_HI/S_PTR_FIN (pointer and operand reads share one port).
// Reset: clears status, program counter, cycle total and all handshake state;
//   accumulator, X, Y and data memory keep their contents until written.
// ----------------------------------------------------------------------------
// adc_instruction_executor: add-with-carry executor, binary mode
// Issue stage resolves addresses against the data memory, finish stage adds
// and updates the architectural registers, an output register holds results.
// ----------------------------------------------------------------------------
module adc_instruction_executor #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Input channel
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [7:0]  req_opcode,
   input  wire logic [7:0]  req_operand_lo,
   input  wire logic [7:0]  req_operand_hi,
   input  wire logic [15:0] req_mem_addr,
   input  wire logic [7:0]  req_write_value,
   input  wire logic [1:0]  req_reg_select,
   input  wire logic [2:0]  req_flag_index,
   input  wire logic        req_flag_value,
   // Result channel
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [7:0]       rsp_acc_out,
   output logic [7:0]       rsp_status_out,
   output logic [15:0]      rsp_pc_out,
   output logic [31:0]      rsp_cycle_total_out,
   output logic [1:0]       rsp_instr_length,
   output logic             rsp_page_crossed,
   output logic             rsp_unknown_opcode
);

   import adc_pkg::*;

   typedef enum logic [3:0] {
      MODE_IMM, MODE_ZP, MODE_ZPX, MODE_ABS, MODE_ABSX,
      MODE_ABSY, MODE_INDX, MODE_INDY, MODE_UNKNOWN
   } mode_type;

   typedef enum logic [1:0] {
      S_IDLE, S_PTR_HI, S_PTR_FIN
   } state_type;

   // Work handed from issue to finish
   typedef struct packed {
      kind_type   kind;
      logic       use_mem;
      logic [7:0] imm;
      logic [7:0] wval;
      logic [1:0] reg_sel;
      logic [2:0] flag_idx;
      logic       flag_val;
      logic [1:0] len;
      logic       crossed;
      logic       unknown;
      logic [2:0] cost;
   } fin_type;

   // Control registers
   state_type   st_ff, st_in;
   logic        fin_valid_ff, fin_valid_in;
   logic        out_valid_ff, out_valid_in;
   // Issue payload
   logic        indy_ff, indy_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic [7:0]  plo_ff, plo_in;
   fin_type     fin_ff, fin_in;
   // Architectural registers
   logic [7:0]  acc_ff, acc_in;
   logic [7:0]  x_ff, x_in;
   logic [7:0]  y_ff, y_in;
   logic [7:0]  status_ff, status_in;
   logic [15:0] pc_ff, pc_in;
   logic [31:0] cyc_ff, cyc_in;
   // Result register
   logic [1:0]  len_out_ff;
   logic        crossed_out_ff;
   logic        unknown_out_ff;

   logic        fin_fire;
   logic        req_fire;
   mode_type    mode;
   logic [7:0]  x_eff;
   logic [7:0]  y_eff;
   logic [7:0]  zpx;
   logic [8:0]  absx_lo;
   logic [8:0]  absy_lo;
   logic [8:0]  indy_lo;
   logic [7:0]  operand;
   alu_out_type alu_res;

   logic                     mem_wr_en;
   logic [MEM_ADDR_BITS-1:0] mem_wr_addr;
   logic                     mem_rd_en;
   logic [15:0]              rd_addr16;
   logic [7:0]               mem_rd_data;

   // Handshake: accept only in S_IDLE with the finish stage free or freeing
   assign fin_fire  = fin_valid_ff & (~out_valid_ff | rsp_ready);
   assign req_ready = (st_ff == S_IDLE) & (~fin_valid_ff | fin_fire);
   assign req_fire  = req_valid & req_ready;

   // Decode the addressing mode
   always_comb begin
      unique case (req_opcode)
         OP_IMM:  mode = MODE_IMM;
         OP_ZP:   mode = MODE_ZP;
         OP_ZPX:  mode = MODE_ZPX;
         OP_ABS:  mode = MODE_ABS;
         OP_ABSX: mode = MODE_ABSX;
         OP_ABSY: mode = MODE_ABSY;
         OP_INDX: mode = MODE_INDX;
         OP_INDY: mode = MODE_INDY;
         default: mode = MODE_UNKNOWN;
      endcase
   end

   // Forward an index preset that finishes in the accept cycle
   always_comb begin
      x_eff = x_ff;
      y_eff = y_ff;
      if (fin_fire && fin_ff.kind == KIND_PRESET_REG) begin
         if (fin_ff.reg_sel == SEL_X) x_eff = fin_ff.wval;
         if (fin_ff.reg_sel == SEL_Y) y_eff = fin_ff.wval;
      end
   end

   assign zpx     = req_operand_lo + x_eff;
   assign absx_lo = {1'b0, req_operand_lo} + {1'b0, x_eff};
   assign absy_lo = {1'b0, req_operand_lo} + {1'b0, y_eff};
   assign indy_lo = {1'b0, plo_ff} + {1'b0, y_ff};

   // Issue stage: address generation, memory reads and loads
   always_comb begin
      st_in       = st_ff;
      indy_in     = indy_ff;
      ptr_in      = ptr_ff;
      plo_in      = plo_ff;
      fin_in      = fin_ff;
      mem_wr_en   = 1'b0;
      mem_wr_addr = req_mem_addr[MEM_ADDR_BITS-1:0];
      mem_rd_en   = 1'b0;
      rd_addr16   = {8'd0, req_operand_lo};
      fin_valid_in = fin_valid_ff & ~fin_fire;

      unique case (st_ff)
         S_IDLE: begin
            if (req_fire) begin
               fin_in.kind     = kind_type'(req_kind);
               fin_in.use_mem  = 1'b0;
               fin_in.imm      = req_operand_lo;
               fin_in.wval     = req_write_value;
               fin_in.reg_sel  = req_reg_select;
               fin_in.flag_idx = req_flag_index;
               fin_in.flag_val = req_flag_value;
               fin_in.len      = 2'd0;
               fin_in.crossed  = 1'b0;
               fin_in.unknown  = 1'b0;
               fin_in.cost     = 3'd0;
               fin_valid_in    = 1'b1;
               if (kind_type'(req_kind) == KIND_LOAD) begin
                  mem_wr_en = 1'b1;
               end else if (kind_type'(req_kind) == KIND_EXEC) begin
                  fin_in.len     = 2'd2;
                  fin_in.use_mem = 1'b1;
                  mem_rd_en      = 1'b1;
                  unique case (mode)
                     MODE_IMM: begin
                        fin_in.use_mem = 1'b0;
                        mem_rd_en      = 1'b0;
                        fin_in.cost    = 3'd2;
                     end
                     MODE_ZP: begin
                        fin_in.cost = 3'd3;
                     end
                     MODE_ZPX: begin
                        rd_addr16   = {8'd0, zpx};
                        fin_in.cost = 3'd4;
                     end
                     MODE_ABS: begin
                        rd_addr16   = {req_operand_hi, req_operand_lo};
                        fin_in.len  = 2'd3;
                        fin_in.cost = 3'd4;
                     end
                     MODE_ABSX: begin
                        rd_addr16      = {req_operand_hi + {7'd0, absx_lo[8]}, absx_lo[7:0]};
                        fin_in.len     = 2'd3;
                        fin_in.cost    = 3'd4;
                        fin_in.crossed = absx_lo[8];
                     end
                     MODE_ABSY: begin
                        rd_addr16      = {req_operand_hi + {7'd0, absy_lo[8]}, absy_lo[7:0]};
                        fin_in.len     = 2'd3;
                        fin_in.cost    = 3'd4;
                        fin_in.crossed = absy_lo[8];
                     end
                     MODE_INDX: begin
                        rd_addr16    = {8'd0, zpx};
                        ptr_in       = zpx + 8'd1;
                        indy_in      = 1'b0;
                        st_in        = S_PTR_HI;
                        fin_valid_in = 1'b0;
                     end
                     MODE_INDY: begin
                        ptr_in       = req_operand_lo + 8'd1;
                        indy_in      = 1'b1;
                        st_in        = S_PTR_HI;
                        fin_valid_in = 1'b0;
                     end
                     default: begin
                        fin_in.use_mem = 1'b0;
                        mem_rd_en      = 1'b0;
                        fin_in.len     = 2'd1;
                        fin_in.unknown = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_PTR_HI: begin
            // Capture the pointer low byte, fetch the high byte
            plo_in    = mem_rd_data;
            rd_addr16 = {8'd0, ptr_ff};
            mem_rd_en = 1'b1;
            st_in     = S_PTR_FIN;
         end
         S_PTR_FIN: begin
            // Pointer complete: fetch the operand and hand over to finish
            mem_rd_en      = 1'b1;
            fin_in.kind    = KIND_EXEC;
            fin_in.use_mem = 1'b1;
            fin_in.len     = 2'd2;
            fin_in.unknown = 1'b0;
            if (indy_ff) begin
               rd_addr16      = {mem_rd_data + {7'd0, indy_lo[8]}, indy_lo[7:0]};
               fin_in.crossed = indy_lo[8];
               fin_in.cost    = 3'd5;
            end else begin
               rd_addr16      = {mem_rd_data, plo_ff};
               fin_in.crossed = 1'b0;
               fin_in.cost    = 3'd6;
            end
            fin_valid_in = 1'b1;
            st_in        = S_IDLE;
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase
   end

   adc_mem #(
      .ADDR_BITS (MEM_ADDR_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (req_write_value),
      .rd_en   (mem_rd_en),
      .rd_addr (rd_addr16[MEM_ADDR_BITS-1:0]),
      .rd_data (mem_rd_data)
   );

   // Finish stage: add, presets, program counter and cycle total
   assign operand = fin_ff.use_mem ? mem_rd_data : fin_ff.imm;

   adc_alu u_alu (
      .acc     (acc_ff),
      .status  (status_ff),
      .operand (operand),
      .result  (alu_res)
   );

   always_comb begin
      acc_in    = acc_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      status_in = status_ff;
      pc_in     = pc_ff + {14'd0, fin_ff.len};
      cyc_in    = cyc_ff + {29'd0, fin_ff.cost} + {31'd0, fin_ff.crossed};
      unique case (fin_ff.kind)
         KIND_EXEC: begin
            if (!fin_ff.unknown) begin
               acc_in    = alu_res.sum;
               status_in = alu_res.status;
            end
         end
         KIND_PRESET_REG: begin
            case (fin_ff.reg_sel)
               SEL_A:   acc_in = fin_ff.wval;
               SEL_X:   x_in   = fin_ff.wval;
               SEL_Y:   y_in   = fin_ff.wval;
               default: acc_in = acc_ff;
            endcase
         end
         KIND_PRESET_FLAG: begin
            status_in[fin_ff.flag_idx] = fin_ff.flag_val;
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   // Result register: fill on finish, drop on transfer
   assign out_valid_in = fin_fire | (out_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         status_ff    <= 8'd0;
         pc_ff        <= 16'd0;
         cyc_ff       <= 32'd0;
      end else begin
         st_ff        <= st_in;
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
         if (fin_fire) begin
            status_ff <= status_in;
            pc_ff     <= pc_in;
            cyc_ff    <= cyc_in;
         end
      end
      // Payload without reset
      indy_ff <= indy_in;
      ptr_ff  <= ptr_in;
      plo_ff  <= plo_in;
      fin_ff  <= fin_in;
      if (fin_fire) begin
         acc_ff         <= acc_in;
         x_ff           <= x_in;
         y_ff           <= y_in;
         len_out_ff     <= fin_ff.len;
         crossed_out_ff <= fin_ff.crossed;
         unknown_out_ff <= fin_ff.unknown;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_acc_out         = acc_ff;
   assign rsp_status_out      = status_ff;
   assign rsp_pc_out          = pc_ff;
   assign rsp_cycle_total_out = cyc_ff;
   assign rsp_instr_length    = len_out_ff;
   assign rsp_page_crossed    = crossed_out_ff;
   assign rsp_unknown_opcode  = unknown_out_ff;

   // The final pointer step always finds the finish stage empty
   a_fin_free_at_ptr: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_PTR_FIN) |-> !fin_valid_ff)
      else $error("finish stage busy during final pointer step");

   // A stalled finish item is never lost
   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (fin_valid_ff && !fin_fire) |=> fin_valid_ff)
      else $error("finish item dropped while stalled");

   // Loads and reads never share a cycle on the memory
   a_mem_port: assert property (@(posedge clock) disable iff (reset)
      !(mem_wr_en && mem_rd_en))
      else $error("memory read and write in the same cycle");

endmodule : adc_instruction_executor
`default_nettype wire
